>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the stable priority queue.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is high.
`define SPQ_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stable_priority_queue: assertion failed");

// Checked property, also checked during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stable_priority_queue: assertion failed");

`endif

>>> sv/spq_pkg.sv
// Package for the stable priority queue: payload structs, codes, defaults,
// and the command/status structs between controller and datapath. No deps.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEFAULT         = 16;
  localparam int PRIORITY_BITS_DEFAULT = 16;
  localparam int DATA_W                = 32;
  localparam int IN_PRIO_W             = 16;
  localparam int COUNT_W               = 5;
  localparam int STATUS_W              = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] item_data;
    logic [IN_PRIO_W-1:0]     item_priority;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_data;
    logic signed [DATA_W-1:0] rear_data;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic                load;
    logic                rd;
    logic                ins_cmp;
    logic                ins_put;
    logic                rem_cmp;
    logic                rem_end;
    logic                emit;
    logic [STATUS_W-1:0] code;
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_ins;
    logic full;
    logic empty;
    logic count_one;
    logic place;
    logic idx_one;
    logic rem_last;
    logic out_free;
  } spq_stat_t;

endpackage

`default_nettype wire

>>> sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/spq_ctrl.sv
// Sequencer for the stable priority queue: walks insert and remove shifts.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire spq_stat_t stat,
  output spq_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_RD,
    S_REM_CMP,
    S_REM_END,
    S_FIN
  } state_t;

  state_t              state;
  logic [STATUS_W-1:0] code;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.code    = code;
    cmd.load    = (state == S_IDLE) && in_valid;
    cmd.rd      = (state == S_INS_RD) || (state == S_REM_RD);
    cmd.ins_cmp = (state == S_INS_CMP);
    cmd.ins_put = (state == S_INS_PUT);
    cmd.rem_cmp = (state == S_REM_CMP);
    cmd.rem_end = (state == S_REM_END);
    cmd.emit    = (state == S_FIN) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          if (stat.is_ins) begin
            if (stat.full) begin
              code  <= ST_OVERFLOW;
              state <= S_FIN;
            end else begin
              code <= ST_OK;
              if (stat.empty) begin
                state <= S_INS_PUT;
              end else begin
                state <= S_INS_RD;
              end
            end
          end else begin
            if (stat.empty) begin
              code  <= ST_UNDERFLOW;
              state <= S_FIN;
            end else begin
              code <= ST_OK;
              if (stat.count_one) begin
                state <= S_REM_END;
              end else begin
                state <= S_REM_RD;
              end
            end
          end
        end
        S_INS_RD:  state <= S_INS_CMP;
        S_INS_CMP: begin
          // stop at the first entry from the rear that is not above the new one
          if (stat.place || stat.idx_one) begin
            state <= S_INS_PUT;
          end else begin
            state <= S_INS_RD;
          end
        end
        S_INS_PUT: state <= S_FIN;
        S_REM_RD:  state <= S_REM_CMP;
        S_REM_CMP: begin
          if (stat.rem_last) begin
            state <= S_REM_END;
          end else begin
            state <= S_REM_RD;
          end
        end
        S_REM_END: state <= S_FIN;
        S_FIN: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/spq_datapath.sv
// Datapath of the stable priority queue: entry RAM, count, front/rear
// tracking and result register. Depends on spq_pkg and spq_ram.
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire spq_cmd_t cmd,
  output spq_stat_t     stat,
  output logic [$clog2(DEPTH+1)-1:0] cnt,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = PRIORITY_BITS + DATA_W;

  // held item
  logic                     op;
  logic [DATA_W-1:0]        held_data;
  logic [PRIORITY_BITS-1:0] new_prio;

  logic [CW-1:0]     idx;
  logic [DATA_W-1:0] front;
  logic [DATA_W-1:0] rear;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic              place;

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_prio   = ram_rdata[EW-1:DATA_W];
  assign place     = (rd_prio <= new_prio);
  assign ram_raddr = (op == OP_INSERT) ? AW'(idx - CW'(1)) : AW'(idx + CW'(1));
  assign ram_we    = cmd.ins_put || (cmd.ins_cmp && !place) || cmd.rem_cmp;
  assign ram_waddr = AW'(idx);
  assign ram_wdata = cmd.ins_put ? {new_prio, held_data} : ram_rdata;

  always_comb begin
    stat           = '0;
    stat.is_ins    = (op == OP_INSERT);
    stat.full      = (cnt == CW'(DEPTH));
    stat.empty     = (cnt == '0);
    stat.count_one = (cnt == CW'(1));
    stat.place     = place;
    stat.idx_one   = (idx == CW'(1));
    stat.rem_last  = ((CW+1)'(idx) + (CW+1)'(2)) >= (CW+1)'(cnt);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= in_item.opcode;
      held_data <= in_item.item_data;
      new_prio  <= PRIORITY_BITS'(in_item.item_priority);
    end
    if (cmd.load) begin
      idx <= (in_item.opcode == OP_INSERT) ? cnt : '0;
    end else if (cmd.ins_cmp && !place) begin
      idx <= idx - CW'(1);
    end else if (cmd.rem_cmp) begin
      idx <= idx + CW'(1);
    end
    if (cmd.ins_put) begin
      if (idx == '0) begin
        front <= held_data;
      end
      if (idx == cnt) begin
        rear <= held_data;
      end
    end
    if (cmd.rem_cmp && idx == '0) begin
      front <= ram_rdata[DATA_W-1:0];
    end
    if (cmd.emit) begin
      out_item.status      <= cmd.code;
      out_item.entry_count <= COUNT_W'(cnt);
      out_item.is_empty    <= (cnt == '0);
      out_item.front_data  <= (cnt == '0) ? '0 : front;
      out_item.rear_data   <= (cnt == '0) ? '0 : rear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_put) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.rem_end) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl, spq_datapath, spq_ram, assert_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------
//   input   | in_valid / in_ready  | in_item  (in_item_t)
//   output  | out_valid / out_ready| out_item (out_item_t)
//
// One transaction at a time; a result waits in the output register while
// the next input transaction is taken and worked on.
// Insert: entries of higher priority value are shifted back one at a time,
// each with a RAM read plus compare, then the new entry is written. Remove:
// every remaining entry is shifted forward the same way. Overflow or underflow
// goes straight to the result. A stalled output holds the last step.
// Reset clears the count and the output valid; the entry RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  spq_cmd_t                   cmd;
  spq_stat_t                  stat;
  logic [$clog2(DEPTH+1)-1:0] cnt;

  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  spq_datapath #(
    .DEPTH        (DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .cnt      (cnt),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  `SPQ_ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `SPQ_ASSERT_CLK(a_emit_sets_valid, clk, rst, cmd.emit |=> out_valid)
  `SPQ_ASSERT_CLK(a_no_emit_on_stall, clk, rst, (out_valid && !out_ready) |-> !cmd.emit)
  `SPQ_ASSERT_CLK(a_count_bound, clk, rst, cnt <= ($clog2(DEPTH+1))'(DEPTH))
  `SPQ_ASSERT_ALWAYS(a_reset_clears_valid, clk, rst |=> !out_valid)

endmodule

`default_nettype wire

>>> bench/spq_result_checker.sv
// Result checker for the stable priority queue: tracks the sorted contents,
// predicts each result and compares it with what comes out. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_result_checker
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        results_pending
);

  localparam logic [IN_PRIO_W-1:0] PRIO_MASK = IN_PRIO_W'((64'd1 << PRIORITY_BITS) - 64'd1);

  // shadow copy of the queue contents, kept in sorted order
  logic signed [DATA_W-1:0] sorted_data [DEPTH];
  logic [IN_PRIO_W-1:0]     sorted_prio [DEPTH];
  int                       stored = 0;

  out_item_t expected_q [$];
  out_item_t want;
  out_item_t next_result;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  task automatic apply_queue_op(input in_item_t op, output out_item_t res);
    logic [IN_PRIO_W-1:0] prio;
    int                   pos;
    prio       = op.item_priority & PRIO_MASK;
    res.status = ST_OK;
    if (op.opcode == OP_INSERT) begin
      if (stored >= DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        // new entry goes behind every entry of equal or lower priority value
        pos = 0;
        while (pos < stored && sorted_prio[pos] <= prio) pos++;
        for (int i = stored; i > pos; i--) begin
          sorted_data[i] = sorted_data[i-1];
          sorted_prio[i] = sorted_prio[i-1];
        end
        sorted_data[pos] = op.item_data;
        sorted_prio[pos] = prio;
        stored++;
      end
    end else if (stored == 0) begin
      res.status = ST_UNDERFLOW;
    end else begin
      for (int i = 0; i + 1 < stored; i++) begin
        sorted_data[i] = sorted_data[i+1];
        sorted_prio[i] = sorted_prio[i+1];
      end
      stored--;
    end
    res.entry_count = COUNT_W'(stored);
    res.is_empty    = (stored == 0);
    res.front_data  = (stored == 0) ? '0 : sorted_data[0];
    res.rear_data   = (stored == 0) ? '0 : sorted_data[stored-1];
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stored = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_item.status));
          check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(out_item.entry_count));
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_item.is_empty));
          check_field("front_data", want.front_data, out_item.front_data);
          check_field("rear_data", want.rear_data, out_item.rear_data);
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_op(in_item, next_result);
        expected_q.push_back(next_result);
      end
    end
    results_pending = expected_q.size();
  end

endmodule

>>> bench/stable_priority_queue_tb.sv
// Testbench top for the stable priority queue: clock, reset, stimulus and
// verdict. Uses spq_pkg, stable_priority_queue and spq_result_checker.
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int PRIORITY_BITS  = PRIORITY_BITS_DEFAULT;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 190;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      holdoff_go = 1'b0;

  int mismatch_count;
  int results_pending;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  int insert_pct = 75;

  int sender_idle_tab [4]    = '{0, 61, 0, 11};
  int receiver_stall_tab [4] = '{0, 0, 61, 11};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_priority_queue #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  spq_result_checker #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_go) begin
      hold_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic offer(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic offer_insert(input logic [DATA_W-1:0] data, input logic [IN_PRIO_W-1:0] prio);
    in_item_t it;
    it.opcode        = OP_INSERT;
    it.item_data     = data;
    it.item_priority = prio;
    offer(it);
  endtask

  task automatic offer_remove(input logic [DATA_W-1:0] data, input logic [IN_PRIO_W-1:0] prio);
    in_item_t it;
    it.opcode        = OP_REMOVE;
    it.item_data     = data;
    it.item_priority = prio;
    offer(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  function automatic in_item_t random_item(input int ins_pct);
    in_item_t it;
    int       pick;
    it.opcode    = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
    it.item_data = $urandom;
    if ($urandom_range(15) == 0)
      it.item_data = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    pick = $urandom_range(9);
    // narrow range half of the time so equal priorities are common
    if (pick < 5)
      it.item_priority = IN_PRIO_W'($urandom_range(3));
    else if (pick < 7)
      it.item_priority = pick[0] ? '1 : '0;
    else
      it.item_priority = IN_PRIO_W'($urandom_range(65535));
    return it;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow, extremes, ties at both ends, drain to empty
    offer_remove(32'hffff_ffff, 16'hffff);
    offer_insert(32'h7fff_ffff, 16'hffff);
    offer_insert(32'h8000_0000, 16'h0000);
    offer_insert(32'h0000_0000, 16'hffff);
    offer_insert(32'hffff_ffff, 16'h0000);
    offer_insert(32'h1234_5678, 16'h8000);
    offer_insert(32'h5a5a_a5a5, 16'h8000);
    repeat (6) offer_remove(32'h0000_0000, 16'h0000);
    offer_remove(32'ha5a5_5a5a, 16'h7fff);
    wait_drained();

    // fill to capacity and beyond, with the result side held off at the start
    holdoff_go <= 1'b1;
    @(posedge clk);
    holdoff_go <= 1'b0;
    for (int n = 0; n < DEPTH + 4; n++)
      offer_insert($urandom, IN_PRIO_W'($urandom_range(3)));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = sender_idle_tab[phase];
      receiver_stall_pct = receiver_stall_tab[phase];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate fill-heavy and drain-heavy bursts
        if (n % 40 == 0) insert_pct = (insert_pct == 75) ? 30 : 75;
        offer(random_item(insert_pct));
      end
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
